### hdl/slbm_pkg.sv
// Package for the stage latency budget monitor: function codes, controller
// states, the statistics record type and the divider control type. No dependencies.
`timescale 1ns / 1ps
package slbm_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned TotalW = 48;
  localparam int unsigned WorstW = 32;
  localparam int unsigned BudgetW = 32;
  localparam int unsigned PpmW = 52;
  localparam int unsigned StageW = 3;
  localparam logic [19:0] PpmScale = 20'd1000000;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_SPARE  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD,
    ST_WR,
    ST_SCAN_RD,
    ST_SCAN_MUL,
    ST_SCAN_DIV,
    ST_SCAN_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [TotalW-1:0] total;
    logic [WorstW-1:0] worst;
  } stat_t;

  typedef struct packed {
    logic       start;
    logic       busy;
  } div_ctl_t;

endpackage

### hdl/slbm_div.sv
// Restoring divider, one quotient bit per cycle: 52-bit dividend by 32-bit
// divisor. Uses slbm_pkg.
`timescale 1ns / 1ps
module slbm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [slbm_pkg::PpmW-1:0] dividend_i,
  input  logic [slbm_pkg::BudgetW-1:0] divisor_i,
  output slbm_pkg::div_ctl_t        ctl_o,
  output logic [slbm_pkg::PpmW-1:0] quot_o
);
  import slbm_pkg::*;

  logic [PpmW-1:0]    quot_q, quot_d;
  logic [BudgetW:0]   rem_q, rem_d;
  logic [BudgetW-1:0] dvs_q, dvs_d;
  logic [5:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [BudgetW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[BudgetW-1:0], quot_q[PpmW-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 6'(PpmW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quot_d = {quot_q[PpmW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[PpmW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign quot_o      = quot_q;
endmodule

### hdl/slbm_mem.sv
// Statistics memory: one synchronous read port with a registered output and
// one write port. Uses slbm_pkg.
`timescale 1ns / 1ps
module slbm_mem #(
  parameter int unsigned Depth = 7
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  slbm_pkg::stat_t                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output slbm_pkg::stat_t                             rdata_o
);
  import slbm_pkg::*;

  stat_t mem [Depth];
  stat_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### hdl/stage_latency_budget_monitor_top.sv
// Stage latency budget monitor, top level. Instantiates slbm_mem and slbm_div
// and uses slbm_pkg.
`timescale 1ns / 1ps
// Usage: an input word (func_i, stage_i, duration_ns_i) is taken when
// in_valid_i is high and in_stall_o is low. Record adds a sample to a stage,
// query reads it, clear zeroes every stage. Each word yields one result word
// on out_valid_o, taken when out_stall_i is low; it reports the addressed
// stage after the update and summary figures over all stages.
// The statistics live in a small synchronous memory. An item reads and
// writes back its own entry, then scans every stage in turn: a read, a
// multiply by one million, a divide by the budget and an accumulate. A
// stage with a budget waits on the bit-serial divider; a stage without one
// skips the divide. The input stays stalled until the result word is
// handed on, and a clear word first sweeps the memory to zero.
// The result waits in its own output register, so the next word is taken
// while it is stalled; a second finished result waits in the controller,
// which keeps the input stalled until the first has been taken.
// After reset the memory is swept to zero, entry by entry, while the
// input is stalled; the budget registers reset to zero. Configuration
// writes (cfg_we_i, cfg_idx_i, cfg_data_i) are meant for idle periods.
module stage_latency_budget_monitor_top #(
  parameter int unsigned STAGES = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [2:0]  stage_i,
  input  logic [31:0] duration_ns_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  report_stage_o,
  output logic        budget_set_o,
  output logic [31:0] samples_o,
  output logic [31:0] worst_ns_o,
  output logic [47:0] sum_ns_o,
  output logic [51:0] load_ppm_o,
  output logic        exceeded_o,
  output logic [2:0]  over_count_o,
  output logic        offender_valid_o,
  output logic [2:0]  offender_stage_o
);
  import slbm_pkg::*;

  localparam int unsigned AW = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int unsigned NumBudgets = 7;

  // One finished result word as it is presented on the output ports.
  typedef struct packed {
    logic [StageW-1:0] stage;
    logic              budget_set;
    stat_t             stat;
    logic [PpmW-1:0]   ppm;
    logic              over;
    logic [2:0]        nexc;
    logic              offv;
    logic [StageW-1:0] offs;
  } res_t;

  // Budget registers, one for each of register indices zero to six.
  logic [BudgetW-1:0] budget_q [NumBudgets];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBudgets; i++) begin
        budget_q[i] <= '0;
      end
    end else if (cfg_we_i && (32'(cfg_idx_i) < NumBudgets)) begin
      budget_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  function automatic logic [BudgetW-1:0] budget_at(input logic [StageW-1:0] s,
                                                   input logic [BudgetW-1:0] b [NumBudgets]);
    logic [BudgetW-1:0] r;
    r = '0;
    for (int i = 0; i < NumBudgets; i++) begin
      if (32'(s) == i && i < STAGES) begin
        r = b[i];
      end
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic [1:0]        func_q, func_d;
  logic [StageW-1:0] stage_q, stage_d;
  logic [31:0]       dur_q, dur_d;
  logic [StageW-1:0] scan_q, scan_d;
  logic [StageW:0]   clr_q, clr_d;
  stat_t             rep_q, rep_d;
  logic [PpmW-1:0]   rep_ppm_q, rep_ppm_d;
  logic [PpmW-1:0]   prod_q, prod_d;
  logic [2:0]        exc_q, exc_d;
  logic              offv_q, offv_d;
  logic [StageW-1:0] offs_q, offs_d;
  logic [PpmW-1:0]   best_q, best_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;
  logic              res_load;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  stat_t             mem_wdata, mem_rdata, upd;
  logic              div_go_q;
  logic              div_launch;
  div_ctl_t          div_ctl;
  logic [PpmW-1:0]   div_quot;
  logic [BudgetW-1:0] scan_budget, rep_budget;
  logic              in_ok, scan_has;
  logic [TotalW:0]   tot_sum;

  slbm_mem #(.Depth(STAGES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  slbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_launch),
    .dividend_i (prod_q),
    .divisor_i  (scan_budget),
    .ctl_o      (div_ctl),
    .quot_o     (div_quot)
  );

  assign in_ok       = 32'(stage_q) < STAGES;
  assign scan_budget = budget_at(scan_q, budget_q);
  assign rep_budget  = budget_at(stage_q, budget_q);
  assign scan_has    = (scan_budget != '0) && (mem_rdata.count != '0);
  assign tot_sum     = {1'b0, mem_rdata.total} + (TotalW+1)'(dur_q);

  // Read-modify-write of the addressed entry.
  always_comb begin
    upd = mem_rdata;
    if (mem_rdata.count != '1) begin
      upd.count = mem_rdata.count + 1'b1;
    end
    upd.total = tot_sum[TotalW] ? '1 : tot_sum[TotalW-1:0];
    if (dur_q > mem_rdata.worst) begin
      upd.worst = dur_q;
    end
  end

  // Next state. A clear word goes on into the scan once its sweep is done;
  // the sweep after reset returns to idle.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (32'(clr_q) >= STAGES - 1) begin
                     state_d = (func_q == FUNC_CLEAR) ? ST_RD : ST_IDLE;
                   end
      ST_IDLE:     if (in_valid_i) begin
                     state_d = (func_i == FUNC_CLEAR) ? ST_CLEAR : ST_RD;
                   end
      ST_RD:       state_d = ST_WR;
      ST_WR:       state_d = ST_SCAN_RD;
      ST_SCAN_RD:  state_d = ST_SCAN_MUL;
      ST_SCAN_MUL: state_d = ST_SCAN_DIV;
      ST_SCAN_DIV: if (!div_ctl.busy && !div_ctl.start) state_d = ST_SCAN_ACC;
      ST_SCAN_ACC: state_d = (32'(scan_q) >= STAGES - 1) ? ST_DONE : ST_SCAN_RD;
      ST_DONE:     if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the controller.
  always_comb begin
    func_d = func_q; stage_d = stage_q; dur_d = dur_q; scan_d = scan_q;
    clr_d = clr_q; rep_d = rep_q; rep_ppm_d = rep_ppm_q; prod_d = prod_q;
    exc_d = exc_q; offv_d = offv_q; offs_d = offs_q; best_d = best_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
    res_load = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = AW'(clr_q);
        clr_d = clr_q + 1'b1;
        // A clear item continues into the scan once the sweep is done.
        if (32'(clr_q) >= STAGES - 1 && func_q == FUNC_CLEAR) begin
          func_d = FUNC_QUERY;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i; stage_d = stage_i; dur_d = duration_ns_i;
          clr_d = '0;
        end
      end
      ST_RD: begin
        mem_raddr = AW'(stage_q);
      end
      ST_WR: begin
        if (func_q == FUNC_RECORD && in_ok) begin
          mem_we = 1'b1; mem_waddr = AW'(stage_q); mem_wdata = upd;
        end
        scan_d = '0; exc_d = '0; offv_d = 1'b0; offs_d = '0; best_d = '0;
        rep_d = '0; rep_ppm_d = '0;
      end
      ST_SCAN_RD: begin
        mem_raddr = AW'(scan_q);
      end
      ST_SCAN_MUL: begin
        mem_raddr = AW'(scan_q);
        prod_d = PpmW'(mem_rdata.worst) * PpmW'(PpmScale);
      end
      ST_SCAN_DIV: begin
        mem_raddr = AW'(scan_q);
      end
      ST_SCAN_ACC: begin
        mem_raddr = AW'(scan_q);
        if (scan_has) begin
          if (mem_rdata.worst > scan_budget) exc_d = exc_q + 1'b1;
          if (!offv_q || div_quot > best_q) begin
            offv_d = 1'b1; best_d = div_quot; offs_d = scan_q;
          end
        end
        if (scan_q == stage_q) begin
          rep_d = mem_rdata;
          rep_ppm_d = (scan_budget == '0) ? '0 : div_quot;
        end
        scan_d = scan_q + 1'b1;
      end
      ST_DONE: begin
        // The result register is free or is being emptied at this edge.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          res_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result word, taken from the scan figures when the controller finishes.
  always_comb begin
    res_d = res_q;
    if (res_load) begin
      res_d.stage      = stage_q;
      res_d.budget_set = in_ok && (rep_budget != '0);
      res_d.stat       = in_ok ? rep_q : '0;
      res_d.ppm        = in_ok ? rep_ppm_q : '0;
      res_d.over       = in_ok && (rep_budget != '0) && (rep_q.count != '0)
                         && (rep_q.worst > rep_budget);
      res_d.nexc       = exc_q;
      res_d.offv       = offv_q;
      res_d.offs       = offv_q ? offs_q : '0;
    end
  end

  // The divide is launched as soon as the registered product is available. A
  // stage without a budget skips it, and its quotient is never used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_go_q <= 1'b0;
    else         div_go_q <= (state_q == ST_SCAN_MUL);
  end
  assign div_launch = div_go_q && (scan_budget != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      func_q <= FUNC_RECORD;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      func_q <= func_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d; dur_q <= dur_d; scan_q <= scan_d; rep_q <= rep_d;
    rep_ppm_q <= rep_ppm_d; prod_q <= prod_d; exc_q <= exc_d; offv_q <= offv_d;
    offs_q <= offs_d; best_q <= best_d; res_q <= res_d;
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign report_stage_o    = res_q.stage;
  assign budget_set_o      = res_q.budget_set;
  assign samples_o         = res_q.stat.count;
  assign worst_ns_o        = res_q.stat.worst;
  assign sum_ns_o          = res_q.stat.total;
  assign load_ppm_o        = res_q.ppm;
  assign exceeded_o        = res_q.over;
  assign over_count_o      = res_q.nexc;
  assign offender_valid_o  = res_q.offv;
  assign offender_stage_o  = res_q.offs;

`ifndef SYNTHESIS
  a_stall_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("input taken while busy");
  a_div_done_before_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_ACC) |-> !div_ctl.busy) else $error("divider still busy");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(offender_stage_o)))
    else $error("stalled result changed");
`endif
endmodule

### tb/slbm_report_checker.sv
// Checker for the stage latency budget monitor: follows the configuration
// port and both word channels, predicts every report and compares it.
// Depends on slbm_pkg for the function codes.
`timescale 1ns / 1ps
module slbm_report_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  func_i,
  input  logic [2:0]  stage_i,
  input  logic [31:0] duration_ns_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  report_stage_i,
  input  logic        budget_set_i,
  input  logic [31:0] samples_i,
  input  logic [31:0] worst_ns_i,
  input  logic [47:0] sum_ns_i,
  input  logic [51:0] load_ppm_i,
  input  logic        exceeded_i,
  input  logic [2:0]  over_count_i,
  input  logic        offender_valid_i,
  input  logic [2:0]  offender_stage_i,
  output int          fail_count_o,
  output int          pending_o
);
  import slbm_pkg::*;

  localparam int unsigned NumStages = 7;

  typedef struct packed {
    logic [2:0]  stage;
    logic        budget_set;
    logic [31:0] count;
    logic [31:0] worst;
    logic [47:0] total;
    logic [51:0] ppm;
    logic        exceeded;
    logic [2:0]  exc_stages;
    logic        off_valid;
    logic [2:0]  off_stage;
  } report_t;

  logic [31:0] budget_mirror [NumStages];
  logic [31:0] count_mirror  [NumStages];
  logic [47:0] total_mirror  [NumStages];
  logic [31:0] worst_mirror  [NumStages];
  report_t     expected_reports [$];

  function automatic logic [63:0] util_ppm(int s);
    logic [63:0] scaled;
    scaled = {32'd0, worst_mirror[s]} * 64'd1000000;
    if (budget_mirror[s] == 0) return 64'd0;
    return scaled / {32'd0, budget_mirror[s]};
  endfunction

  function automatic logic over_budget(int s);
    return budget_mirror[s] != 0 && count_mirror[s] != 0
           && worst_mirror[s] > budget_mirror[s];
  endfunction

  // Applies one word to the mirrored statistics and builds its report.
  task automatic predict_report(input func_e fn, input logic [2:0] st,
                                input logic [31:0] dur);
    report_t     r;
    logic [48:0] sum;
    logic [63:0] best, u;
    r = '0;
    best = '0;
    if (fn == FUNC_CLEAR) begin
      for (int s = 0; s < NumStages; s++) begin
        count_mirror[s] = '0;
        total_mirror[s] = '0;
        worst_mirror[s] = '0;
      end
    end else if (fn == FUNC_RECORD && st < NumStages) begin
      if (count_mirror[st] != 32'hFFFF_FFFF) count_mirror[st]++;
      sum = {1'b0, total_mirror[st]} + {17'd0, dur};
      total_mirror[st] = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
      if (dur > worst_mirror[st]) worst_mirror[st] = dur;
    end
    for (int s = 0; s < NumStages; s++) begin
      if (over_budget(s)) r.exc_stages++;
      if (budget_mirror[s] != 0 && count_mirror[s] != 0) begin
        u = util_ppm(s);
        if (!r.off_valid || u > best) begin
          r.off_valid = 1'b1;
          best = u;
          r.off_stage = s[2:0];
        end
      end
    end
    r.stage = st;
    if (st < NumStages) begin
      r.budget_set = budget_mirror[st] != 0;
      r.count = count_mirror[st];
      r.worst = worst_mirror[st];
      r.total = total_mirror[st];
      r.ppm = 52'(util_ppm(st));
      r.exceeded = over_budget(st);
    end
    expected_reports.insert(expected_reports.size(), r);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    report_t e;
    if (!rst_ni) begin
      for (int s = 0; s < NumStages; s++) begin
        budget_mirror[s] = '0;
        count_mirror[s] = '0;
        total_mirror[s] = '0;
        worst_mirror[s] = '0;
      end
      expected_reports.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < NumStages) budget_mirror[cfg_idx_i] = cfg_data_i;
      if (in_valid_i && !in_stall_i) predict_report(func_e'(func_i), stage_i, duration_ns_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report word for stage %0d", $time, report_stage_i);
          fail_count_o++;
        end else begin
          e = expected_reports.pop_front();
          check_field("report_stage", 64'(e.stage), 64'(report_stage_i));
          check_field("budget_set", 64'(e.budget_set), 64'(budget_set_i));
          check_field("samples", 64'(e.count), 64'(samples_i));
          check_field("worst_ns", 64'(e.worst), 64'(worst_ns_i));
          check_field("sum_ns", 64'(e.total), 64'(sum_ns_i));
          check_field("load_ppm", 64'(e.ppm), 64'(load_ppm_i));
          check_field("exceeded", 64'(e.exceeded), 64'(exceeded_i));
          check_field("over_count", 64'(e.exc_stages), 64'(over_count_i));
          check_field("offender_valid", 64'(e.off_valid), 64'(offender_valid_i));
          check_field("offender_stage", 64'(e.off_stage), 64'(offender_stage_i));
        end
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

### tb/tb_stage_latency_budget_monitor_top.sv
// Testbench top for the stage latency budget monitor: drives reset, budget
// writes and input words, and gives the verdict. Depends on slbm_pkg, the
// RTL top and slbm_report_checker.
`timescale 1ns / 1ps
module tb_stage_latency_budget_monitor_top;
  import slbm_pkg::*;

  localparam int unsigned NumStages = 7;
  // Register index seven has no budget behind it; writes there must be ignored.
  localparam logic [2:0] CfgNoReg = 3'd7;
  localparam logic [2:0] StageNone = 3'd7;
  localparam int unsigned DrainCycles = 600;
  localparam longint unsigned CycleLimit = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = FUNC_QUERY;
  logic [2:0]  stage = '0;
  logic [31:0] duration = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  report_stage, over_count, offender_stage;
  logic        budget_set, exceeded, offender_valid;
  logic [31:0] samples, worst_ns;
  logic [47:0] sum_ns;
  logic [51:0] load_ppm;
  int          fail_count, pending;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  // Bumped by the stimulus to ask the receiver for one long hold-off.
  int unsigned holdoff_token = 0;
  logic [31:0] budget_shadow [NumStages];
  longint unsigned cycle_count = 0;

  always #6 clk = ~clk;

  stage_latency_budget_monitor_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .stage_i(stage), .duration_ns_i(duration),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .report_stage_o(report_stage), .budget_set_o(budget_set),
    .samples_o(samples), .worst_ns_o(worst_ns), .sum_ns_o(sum_ns),
    .load_ppm_o(load_ppm), .exceeded_o(exceeded),
    .over_count_o(over_count), .offender_valid_o(offender_valid),
    .offender_stage_o(offender_stage)
  );

  slbm_report_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .func_i(func), .stage_i(stage), .duration_ns_i(duration),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .report_stage_i(report_stage), .budget_set_i(budget_set),
    .samples_i(samples), .worst_ns_i(worst_ns), .sum_ns_i(sum_ns),
    .load_ppm_i(load_ppm), .exceeded_i(exceeded),
    .over_count_i(over_count), .offender_valid_i(offender_valid),
    .offender_stage_i(offender_stage),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: stalls at random, and on request holds off for a long stretch
  // so that the monitor keeps its result and stalls its own input.
  always @(negedge clk) begin
    static int unsigned holdoff_left = 0;
    static int unsigned holdoff_seen = 0;
    if (holdoff_token != holdoff_seen) begin
      holdoff_seen = holdoff_token;
      holdoff_left = 3000;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  // Budget writes happen only while nothing is in flight. The shadow copy
  // lets the random durations be aimed at the current budgets.
  task automatic write_budgets(input logic [31:0] vals [NumStages]);
    for (int s = 0; s < NumStages; s++) begin
      cfg_we <= 1'b1;
      cfg_idx <= s[2:0];
      cfg_data <= vals[s];
      budget_shadow[s] = vals[s];
      @(negedge clk);
    end
    // A write to the unused index should change nothing at all.
    cfg_idx <= CfgNoReg;
    cfg_data <= $urandom();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one word and returns at the falling edge after it was taken.
  // The stall seen at a falling edge is the one that the next rising edge uses.
  task automatic send_word(input func_e fn, input logic [2:0] st, input logic [31:0] dur);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    stage <= st;
    duration <= dur;
    do begin
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [31:0] random_budget();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(5000, 1);
      default: return $urandom();
    endcase
  endfunction

  // Durations cluster around the stage budget so the exceeded flag and the
  // offender choice flip often, with the full range mixed in.
  function automatic logic [31:0] random_duration(input logic [2:0] st);
    logic [31:0] b;
    b = (st < NumStages) ? budget_shadow[st] : 32'd1000;
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      3: return b;
      4: return b + 1;
      5: return b - $urandom_range(3);
      default: return $urandom_range(2 * (b % 100000) + 10);
    endcase
  endfunction

  task automatic random_words(input int unsigned n);
    func_e       fn;
    logic [2:0]  st;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 72) fn = FUNC_RECORD;
      else if (pick < 88) fn = FUNC_QUERY;
      else if (pick < 93) fn = FUNC_CLEAR;
      else fn = FUNC_SPARE;
      st = $urandom_range(7);
      send_word(fn, st, random_duration(st));
    end
  endtask

  initial begin
    logic [31:0] b [NumStages];
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words, first with every budget still at its reset value.
    send_word(FUNC_RECORD, 3'd0, 32'd500);
    send_word(FUNC_QUERY, 3'd0, 32'd0);
    wait_idle();
    b = '{32'd1000, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd250, 32'd7777, 32'd3};
    write_budgets(b);
    send_word(FUNC_RECORD, 3'd0, 32'd0);
    send_word(FUNC_RECORD, 3'd0, 32'd1001);
    send_word(FUNC_RECORD, 3'd1, 32'hFFFF_FFFF);
    send_word(FUNC_RECORD, 3'd2, 32'hFFFF_FFFF);
    send_word(FUNC_RECORD, 3'd2, 32'd1);
    send_word(FUNC_RECORD, 3'd3, 32'd123456);
    send_word(FUNC_RECORD, 3'd4, 32'd250);
    send_word(FUNC_RECORD, 3'd5, 32'hAAAA_5555);
    send_word(FUNC_RECORD, 3'd6, 32'd4);
    send_word(FUNC_RECORD, 3'd6, 32'h5555_AAAA);
    // An out-of-range stage records nothing but still reports the summary.
    send_word(FUNC_RECORD, StageNone, 32'hFFFF_FFFF);
    send_word(FUNC_QUERY, StageNone, 32'd0);
    send_word(FUNC_SPARE, 3'd5, 32'd99);
    send_word(FUNC_QUERY, 3'd3, 32'hFFFF_FFFF);
    send_word(FUNC_CLEAR, 3'd4, 32'd0);
    send_word(FUNC_QUERY, 3'd0, 32'd0);
    send_word(FUNC_RECORD, 3'd4, 32'd251);
    send_word(FUNC_CLEAR, StageNone, 32'hFFFF_FFFF);
    wait_idle();

    // Sender mostly idle, mixed budgets.
    for (int s = 0; s < NumStages; s++) b[s] = random_budget();
    write_budgets(b);
    idle_pct = 71;
    random_words(150);
    wait_idle();

    // Receiver mostly stalling with maximum budgets, plus one long hold-off
    // while the sender keeps offering words.
    for (int s = 0; s < NumStages; s++) b[s] = 32'hFFFF_FFFF;
    write_budgets(b);
    idle_pct = 0;
    stall_pct = 71;
    holdoff_token++;
    random_words(150);
    wait_idle();

    // Both sides idle a little, with the smallest non-zero budgets.
    for (int s = 0; s < NumStages; s++) b[s] = 32'd1;
    write_budgets(b);
    idle_pct = 15;
    stall_pct = 15;
    random_words(150);
    wait_idle();

    // No idling at all, fresh random budgets.
    for (int s = 0; s < NumStages; s++) b[s] = random_budget();
    write_budgets(b);
    idle_pct = 0;
    stall_pct = 0;
    random_words(150);
    wait_idle();

    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
